>>> design/mtt_pkg.sv
// Package for the timer table: operation codes, status codes, word types.
// No dependencies.
package mtt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_RESET  = 2'd2,
    OP_POLL   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_INT = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOT_FND  = 2'd3
  } status_e;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [5:0]  BUDGET_RST = 6'd16;
  localparam logic [0:0]  REG_BUDGET = 1'b0;

  typedef struct packed {
    logic [1:0]  mode;
    logic        fire_once;
    logic [31:0] interval;
    logic [31:0] expiry_code;
    logic [31:0] event_tag;
    logic [31:0] timer_id;
    logic [31:0] elapsed;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] fired_code;
    logic [31:0] fired_tag;
    logic [31:0] new_id;
    logic [1:0]  status;
    logic [5:0]  emitted;
    logic [31:0] next_delay;
    logic        last;
  } out_word_t;

endpackage

>>> design/mtt_front.sv
// Front end of the timer table: input register stage that holds one word.
// Depends on mtt_pkg.
module mtt_front import mtt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  in_word_t in_word_i,
  output logic     valid_o,
  input  logic     take_i,
  output in_word_t word_o
);

  logic     valid_q;
  in_word_t word_q;

  assign full_o  = valid_q;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i && !valid_q) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !valid_q) begin
      word_q <= in_word_i;
    end
  end

endmodule

>>> design/mtt_outq.sv
// Result queue of the timer table: two-entry FIFO of result words.
// Depends on mtt_pkg.
module mtt_outq import mtt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  out_word_t wr_word_i,
  output logic      full_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_word_t rd_word_o
);

  out_word_t mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic      do_rd;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign rd_word_o = mem_q[rp_q];
  assign do_rd     = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (do_rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_word_i;
  end

endmodule

>>> design/mtt_divider.sv
// Restoring divider, one quotient bit per cycle, for the periodic reload.
// No dependencies.
module mtt_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [31:0] quo_q, rem_q, den_q;
  logic [32:0] trial;

  assign trial  = {rem_q, quo_q[31]} - {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == 6'd32);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && !done_o) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

>>> design/mtt_back.sv
// Back end of the timer table: slot registers and the sequencer that scans
// them for each operation. Depends on mtt_pkg and mtt_divider.
module mtt_back import mtt_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  in_word_t  word_i,
  output logic      take_o,
  input  logic [5:0] budget_i,
  input  logic      oq_full_i,
  output logic      oq_wr_o,
  output out_word_t oq_word_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_EMIT = 7'b0001000,
    S_MIN  = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [SLOTS-1:0] act_q;
  logic             once_q [SLOTS];
  logic [31:0]      ident_q [SLOTS];
  logic [31:0]      per_q [SLOTS];
  logic [31:0]      left_q [SLOTS];
  logic [31:0]      code_q [SLOTS];
  logic [31:0]      tag_q [SLOTS];
  logic [31:0]      idc_q;

  logic [CW-1:0] idx_q;
  logic [IW-1:0] ix;
  logic [1:0]    status_q;
  logic [31:0]   nid_q, best_q, fires_q;
  logic [5:0]    emitted_q;
  logic          found_q;

  logic        div_start, div_done;
  logic [31:0] div_quo, div_rem, past;

  assign ix   = idx_q[IW-1:0];
  assign past = word_i.elapsed - left_q[ix];

  mtt_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (past),
    .den_i   (per_q[ix]),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  logic scan_end;
  assign scan_end = (idx_q == CW'(SLOTS));

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    take_o    = 1'b0;
    oq_wr_o   = 1'b0;
    oq_word_o = '0;
    unique case (state_q)
      S_IDLE: if (valid_i) state_d = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_MIN;
        end else if (word_i.mode == OP_POLL && budget_i != '0 && act_q[ix] &&
                     left_q[ix] <= word_i.elapsed) begin
          if (once_q[ix] || per_q[ix] == '0) begin
            state_d = S_EMIT;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV:  if (div_done) state_d = S_EMIT;
      S_EMIT: begin
        if (fires_q == '0 || emitted_q == budget_i) begin
          state_d = S_SCAN;
        end else if (!oq_full_i) begin
          oq_wr_o              = 1'b1;
          oq_word_o.fired_code = code_q[ix];
          oq_word_o.fired_tag  = tag_q[ix];
        end
      end
      S_MIN:  if (scan_end) state_d = S_SUM;
      S_SUM: begin
        if (!oq_full_i) begin
          oq_wr_o              = 1'b1;
          oq_word_o.kind       = 1'b1;
          oq_word_o.new_id     = nid_q;
          oq_word_o.status     = status_q;
          oq_word_o.emitted    = emitted_q;
          oq_word_o.next_delay = best_q;
          oq_word_o.last       = 1'b1;
          take_o               = 1'b1;
          state_d              = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      act_q     <= '0;
      idc_q     <= 32'd1;
      idx_q     <= '0;
      status_q  <= ST_OK;
      nid_q     <= '0;
      best_q    <= ALL_ONES;
      fires_q   <= '0;
      emitted_q <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          idx_q     <= '0;
          nid_q     <= '0;
          emitted_q <= '0;
          found_q   <= 1'b0;
          best_q    <= ALL_ONES;
          fires_q   <= '0;
          if (word_i.mode == OP_ADD && word_i.interval == '0) begin
            status_q <= ST_ZERO_INT;
          end else if (word_i.mode == OP_ADD) begin
            status_q <= ST_FULL;
          end else if (word_i.mode == OP_POLL) begin
            status_q <= ST_OK;
          end else begin
            status_q <= ST_NOT_FND;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            idx_q <= '0;
          end else begin
            if (state_d == S_SCAN) idx_q <= idx_q + CW'(1);
            case (word_i.mode)
              OP_ADD: begin
                if (word_i.interval != '0 && !found_q && !act_q[ix]) begin
                  found_q  <= 1'b1;
                  status_q <= ST_OK;
                  nid_q    <= idc_q;
                  idc_q    <= (idc_q == ALL_ONES) ? 32'd1 : idc_q + 32'd1;
                  act_q[ix] <= 1'b1;
                end
              end
              OP_REMOVE, OP_RESET: begin
                if (word_i.timer_id != '0 && !found_q && act_q[ix] &&
                    ident_q[ix] == word_i.timer_id) begin
                  found_q  <= 1'b1;
                  status_q <= ST_OK;
                  if (word_i.mode == OP_REMOVE) act_q[ix] <= 1'b0;
                end
              end
              default: begin
                if (budget_i != '0 && act_q[ix]) begin
                  if (left_q[ix] > word_i.elapsed) begin
                    // no expiry
                  end else if (once_q[ix] || per_q[ix] == '0) begin
                    act_q[ix] <= 1'b0;
                    fires_q   <= 32'd1;
                  end
                end
              end
            endcase
          end
        end
        S_DIV: if (div_done) fires_q <= div_quo + 32'd1;
        S_EMIT: begin
          if (fires_q == '0 || emitted_q == budget_i) begin
            fires_q <= '0;
            idx_q   <= idx_q + CW'(1);
          end else if (!oq_full_i) begin
            fires_q   <= fires_q - 32'd1;
            emitted_q <= emitted_q + 6'd1;
          end
        end
        S_MIN: begin
          if (!scan_end) begin
            idx_q <= idx_q + CW'(1);
            if (act_q[ix] && left_q[ix] < best_q) best_q <= left_q[ix];
          end
        end
        default: ;
      endcase
    end
  end

  // Slot payload updates; these registers need no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && !scan_end) begin
      case (word_i.mode)
        OP_ADD: begin
          if (word_i.interval != '0 && !found_q && !act_q[ix]) begin
            ident_q[ix] <= idc_q;
            per_q[ix]   <= word_i.interval;
            left_q[ix]  <= word_i.interval;
            code_q[ix]  <= word_i.expiry_code;
            tag_q[ix]   <= word_i.event_tag;
            once_q[ix]  <= word_i.fire_once;
          end
        end
        OP_RESET: begin
          if (word_i.timer_id != '0 && !found_q && act_q[ix] &&
              ident_q[ix] == word_i.timer_id) begin
            left_q[ix] <= per_q[ix];
          end
        end
        OP_POLL: begin
          if (budget_i != '0 && act_q[ix]) begin
            if (left_q[ix] > word_i.elapsed) begin
              left_q[ix] <= left_q[ix] - word_i.elapsed;
            end else if (once_q[ix] || per_q[ix] == '0) begin
              left_q[ix] <= per_q[ix] - past;
            end
          end
        end
        default: ;
      endcase
    end else if (state_q == S_DIV && div_done) begin
      left_q[ix] <= per_q[ix] - div_rem;
    end
  end

endmodule

>>> design/multi_timer_table.sv
// Top level of the timer table: APB register, front stage, back sequencer
// and result queue. Depends on mtt_pkg, mtt_front, mtt_back and mtt_outq.
//
// Usage: words go in through push/full as in_word_i. Each holds one
// operation (add, remove, reset or poll). Results come out through
// empty/pop as out_word_o: a poll gives its expiry words first, then
// every operation gives one summary word with last set.
// The sequencer visits each slot once for the operation and once more
// for the smallest remaining time, then queues the summary word. In a
// poll each expiring slot also holds the scan, a periodic one waits for
// the divider and the expiry words are queued one after another. One
// item is worked on at a time: it stays in the front register until its
// summary is queued, and only then can the next word be accepted.
// Reset clears all slots, sets the ID counter to one and the event budget
// to 16. When the receiver stalls the result queue fills and the sequencer
// waits. The event budget lies at address 0 and is read back on prdata.
module multi_timer_table import mtt_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  in_word_t    in_word_i,
  output logic        empty,
  input  logic        pop,
  output out_word_t   out_word_o
);

  logic [5:0] budget_q;
  logic       fe_valid, take;
  in_word_t   fe_word;
  logic       oq_full, oq_wr;
  out_word_t  oq_word;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_BUDGET) ? {26'd0, budget_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BUDGET_RST;
    end else if (psel && penable && pwrite && paddr == REG_BUDGET) begin
      budget_q <= pwdata[5:0];
    end
  end

  mtt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_word_i (in_word_i),
    .valid_o   (fe_valid),
    .take_i    (take),
    .word_o    (fe_word)
  );

  mtt_back #(.SLOTS(SLOTS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (fe_valid),
    .word_i    (fe_word),
    .take_o    (take),
    .budget_i  (budget_q),
    .oq_full_i (oq_full),
    .oq_wr_o   (oq_wr),
    .oq_word_o (oq_word)
  );

  mtt_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (oq_wr),
    .wr_word_i (oq_word),
    .full_o    (oq_full),
    .empty_o   (empty),
    .pop_i     (pop),
    .rd_word_o (out_word_o)
  );

endmodule

>>> design/mtt_checker.sv
// Port checker for the timer table, bound to the top level.
// Depends on mtt_pkg.
module mtt_checker import mtt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      pop,
  input logic      empty,
  input logic      pready,
  input out_word_t out_word_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty && $stable(out_word_o)) else $error("result changed");
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_word_o.last == out_word_o.kind)) else $error("last/kind mismatch");
  a_event_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_word_o.kind) |-> (out_word_o.status == ST_OK && out_word_o.new_id == '0))
    else $error("event carries summary data");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind multi_timer_table mtt_checker u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pop        (pop),
  .empty      (empty),
  .pready     (pready),
  .out_word_o (out_word_o)
);
